// ===== src/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, pipeline record types and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int WRAP_DEGREES        = 360;
	localparam int DEG_FULL            = WRAP_DEGREES * 128;

	localparam int CVW      = 38;   // CORDIC datapath width
	localparam int SQ_STEPS = 31;   // result bits of the square root
	localparam int SQW      = 63;   // square root working width

	localparam logic [31:0] TURN_HALF  = 32'h8000_0000;
	localparam logic [31:0] TURN_PLUS  = 32'h4000_0000;
	localparam logic [31:0] TURN_MINUS = 32'hC000_0000;

	typedef struct packed {
		logic signed [CVW-1:0] x;
		logic signed [CVW-1:0] y;
		logic [31:0]           ang;
	} vec_t;

	typedef struct packed {
		logic [SQW-1:0] v;
		logic [SQW-1:0] res;
	} sq_t;

	typedef struct packed {
		logic signed [35:0] py;
		logic signed [35:0] px;
		logic signed [35:0] ry;
		logic signed [35:0] rx;
		logic signed [31:0] ys;
		logic               sat_p;
		logic               sat_n;
		logic               nz;
		logic               zero;
	} side_t;

	typedef struct packed {
		logic nil_p;
		logic nil_r;
		logic nil_y;
		logic sat_p;
		logic sat_n;
		logic nz;
		logic zero;
	} flag_t;

	function automatic logic [31:0] atan_turn(input int idx);
		case (idx)
			0:  atan_turn = 32'h20000000;
			1:  atan_turn = 32'h12E4051E;
			2:  atan_turn = 32'h09FB385B;
			3:  atan_turn = 32'h051111D4;
			4:  atan_turn = 32'h028B0D43;
			5:  atan_turn = 32'h0145D7E1;
			6:  atan_turn = 32'h00A2F61E;
			7:  atan_turn = 32'h00517C55;
			8:  atan_turn = 32'h0028BE53;
			9:  atan_turn = 32'h00145F2F;
			10: atan_turn = 32'h000A2F98;
			11: atan_turn = 32'h000517CC;
			12: atan_turn = 32'h00028BE6;
			13: atan_turn = 32'h000145F3;
			14: atan_turn = 32'h0000A2FA;
			15: atan_turn = 32'h0000517D;
			16: atan_turn = 32'h000028BE;
			17: atan_turn = 32'h0000145F;
			18: atan_turn = 32'h00000A30;
			19: atan_turn = 32'h00000518;
			20: atan_turn = 32'h0000028C;
			21: atan_turn = 32'h00000146;
			22: atan_turn = 32'h000000A3;
			23: atan_turn = 32'h00000051;
			24: atan_turn = 32'h00000029;
			25: atan_turn = 32'h00000014;
			26: atan_turn = 32'h0000000A;
			27: atan_turn = 32'h00000005;
			28: atan_turn = 32'h00000003;
			29: atan_turn = 32'h00000001;
			30: atan_turn = 32'h00000001;
			default: atan_turn = 32'h00000000;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== src/q2e_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit step of the restoring integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt_cell
	import q2e_pkg::*;
#(
	parameter int STEP = 0
) (
	input  wire  clk,
	input  wire  en,
	input  sq_t  d,
	output sq_t  q
);

	localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * (SQ_STEPS - 1 - STEP));

	logic [SQW-1:0] trial;
	sq_t nxt;

	always_comb begin
		trial = d.res + BITV;
		if (d.v >= trial) begin
			nxt.v   = d.v - trial;
			nxt.res = (d.res >> 1) + BITV;
		end else begin
			nxt.v   = d.v;
			nxt.res = d.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== src/q2e_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell
	import q2e_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire   clk,
	input  wire   en,
	input  vec_t  d,
	output vec_t  q
);

	localparam logic [31:0] ATN = atan_turn(IDX);

	logic signed [CVW-1:0] dx, dy;
	vec_t nxt;

	always_comb begin
		dx = d.y >>> IDX;
		dy = d.x >>> IDX;
		if (!d.y[CVW-1]) begin
			nxt.x   = d.x + dx;
			nxt.y   = d.y - dy;
			nxt.ang = d.ang + ATN;
		end else begin
			nxt.x   = d.x - dx;
			nxt.y   = d.y + dy;
			nxt.ang = d.ang - ATN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== src/quaternion_to_euler_degrees_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_top
// Quaternion to pitch/yaw/roll in degrees, unsigned Q9.7, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel quat_*: one quaternion per beat, taken when quat_valid is
// high and quat_stall low. Output channel euler_*: one angle set per beat.
// Throughput is one beat per cycle while the pipeline is not held. Stages:
// input load, products, sums, yaw scaling and radicand registers, SQ_STEPS
// square-root digit cells, a CORDIC set-up register, CORDIC_STAGES rotation cells,
// a degree-scaling multiply and the output register.
// The whole pipeline moves together; it holds while euler_valid is high and
// euler_stall is asserted, and quat_stall is raised for that time.
// Reset clears all valid flags; items in flight are dropped.
// A zero quaternion gives zero_input = 1 and all angles zero.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_degrees_top
	import q2e_pkg::*;
#(
	parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              quat_valid,
	output logic                             quat_stall,
	input  wire signed [COMPONENT_WIDTH-1:0] quat_x,
	input  wire signed [COMPONENT_WIDTH-1:0] quat_y,
	input  wire signed [COMPONENT_WIDTH-1:0] quat_z,
	input  wire signed [COMPONENT_WIDTH-1:0] quat_w,
	output logic                             euler_valid,
	input  wire                              euler_stall,
	output logic [15:0]                      pitch_deg,
	output logic [15:0]                      yaw_deg,
	output logic [15:0]                      roll_deg,
	output logic                             zero_input
);

	localparam int MW  = (COMPONENT_WIDTH > 16) ? COMPONENT_WIDTH : 16;
	localparam int SH  = (COMPONENT_WIDTH > 16) ? COMPONENT_WIDTH - 16 : 0;
	localparam int LAT = 39 + CORDIC_STAGES;

	logic en;
	logic [LAT-1:0] vld_q;

	assign en          = !euler_valid || !euler_stall;
	assign quat_stall  = !en;
	assign euler_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], quat_valid};
		end
	end

	// stage 1: load components
	logic signed [MW-1:0] ex, ey, ez, ew;
	logic signed [MW-1:0] hx, hy, hz, hw;
	logic signed [15:0] x_s1, y_s1, z_s1, w_s1;
	logic zero_s1;

	always_comb begin
		ex = MW'(quat_x);
		ey = MW'(quat_y);
		ez = MW'(quat_z);
		ew = MW'(quat_w);
		hx = ex >>> SH;
		hy = ey >>> SH;
		hz = ez >>> SH;
		hw = ew >>> SH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= hx[15:0];
			y_s1    <= hy[15:0];
			z_s1    <= hz[15:0];
			w_s1    <= hw[15:0];
			zero_s1 <= (quat_x == '0) && (quat_y == '0) && (quat_z == '0) && (quat_w == '0);
		end
	end

	// stage 2: products
	logic signed [31:0] xx_s2, yy_s2, zz_s2, ww_s2, wx_s2, yz_s2, wz_s2, xy_s2, wy_s2, zx_s2;
	logic zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2   <= x_s1 * x_s1;
			yy_s2   <= y_s1 * y_s1;
			zz_s2   <= z_s1 * z_s1;
			ww_s2   <= w_s1 * w_s1;
			wx_s2   <= w_s1 * x_s1;
			yz_s2   <= y_s1 * z_s1;
			wz_s2   <= w_s1 * z_s1;
			xy_s2   <= x_s1 * y_s1;
			wy_s2   <= w_s1 * y_s1;
			zx_s2   <= z_s1 * x_s1;
			zero_s2 <= zero_s1;
		end
	end

	// stage 3: sums
	logic signed [35:0] n_s3, py_s3, px_s3, ry_s3, rx_s3, s_s3;
	logic zero_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3  <= 36'(xx_s2) + 36'(yy_s2) + 36'(zz_s2) + 36'(ww_s2);
			py_s3 <= (36'(wx_s2) + 36'(yz_s2)) <<< 1;
			px_s3 <= 36'(xx_s2) + 36'(yy_s2) + 36'(zz_s2) + 36'(ww_s2)
			         - ((36'(xx_s2) + 36'(yy_s2)) <<< 1);
			ry_s3 <= (36'(wz_s2) + 36'(xy_s2)) <<< 1;
			rx_s3 <= 36'(xx_s2) + 36'(yy_s2) + 36'(zz_s2) + 36'(ww_s2)
			         - ((36'(yy_s2) + 36'(zz_s2)) <<< 1);
			s_s3  <= (36'(wy_s2) - 36'(zx_s2)) <<< 1;
			zero_s3 <= zero_s2;
		end
	end

	// stage 4: yaw saturation and scaling
	logic [1:0] k;
	logic signed [35:0] ns, ps, sa;
	logic [35:0] ak, bk, sk;
	logic [30:0] a_s4, b_s4;
	side_t side_s4;

	always_comb begin
		if (n_s3[32]) begin
			k = 2'd3;
		end else if (n_s3[31]) begin
			k = 2'd2;
		end else if (n_s3[30]) begin
			k = 2'd1;
		end else begin
			k = 2'd0;
		end
		ns = n_s3 - s_s3;
		ps = n_s3 + s_s3;
		sa = s_s3[35] ? -s_s3 : s_s3;
		ak = 36'(ns) >> k;
		bk = 36'(ps) >> k;
		sk = 36'(sa) >> k;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4          <= ak[30:0];
			b_s4          <= bk[30:0];
			side_s4.py    <= py_s3;
			side_s4.px    <= px_s3;
			side_s4.ry    <= ry_s3;
			side_s4.rx    <= rx_s3;
			side_s4.ys    <= s_s3[35] ? -$signed(sk[31:0]) : $signed(sk[31:0]);
			side_s4.sat_p <= s_s3 >= n_s3;
			side_s4.sat_n <= -s_s3 >= n_s3;
			side_s4.nz    <= n_s3 == '0;
			side_s4.zero  <= zero_s3;
		end
	end

	// stage 5: radicand
	logic [61:0] prod_s5;
	side_t side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= a_s4 * b_s4;
			side_s5 <= side_s4;
		end
	end

	// square root cells
	sq_t   sq_w [0:SQ_STEPS];
	side_t side_q [0:SQ_STEPS-1];

	assign sq_w[0].v   = SQW'(prod_s5);
	assign sq_w[0].res = '0;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		q2e_sqrt_cell #(.STEP(i)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq_w[i]),
			.q   (sq_w[i+1])
		);
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					side_q[i] <= side_s5;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					side_q[i] <= side_q[i-1];
				end
			end
		end
	end

	// CORDIC set-up
	side_t sd;
	logic signed [CVW-1:0] cx;
	vec_t pv_s6, rv_s6, yv_s6;
	flag_t fl_s6;

	assign sd = side_q[SQ_STEPS-1];
	assign cx = CVW'({1'b0, sq_w[SQ_STEPS].res[30:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			if (sd.px[35]) begin
				pv_s6.x   <= -CVW'(sd.px);
				pv_s6.y   <= -CVW'(sd.py);
				pv_s6.ang <= TURN_HALF;
			end else begin
				pv_s6.x   <= CVW'(sd.px);
				pv_s6.y   <= CVW'(sd.py);
				pv_s6.ang <= '0;
			end
			if (sd.rx[35]) begin
				rv_s6.x   <= -CVW'(sd.rx);
				rv_s6.y   <= -CVW'(sd.ry);
				rv_s6.ang <= TURN_HALF;
			end else begin
				rv_s6.x   <= CVW'(sd.rx);
				rv_s6.y   <= CVW'(sd.ry);
				rv_s6.ang <= '0;
			end
			yv_s6.x     <= cx;
			yv_s6.y     <= CVW'(sd.ys);
			yv_s6.ang   <= '0;
			fl_s6.nil_p <= (sd.px == '0) && (sd.py == '0);
			fl_s6.nil_r <= (sd.rx == '0) && (sd.ry == '0);
			fl_s6.nil_y <= (cx == '0) && (sd.ys == '0);
			fl_s6.sat_p <= sd.sat_p;
			fl_s6.sat_n <= sd.sat_n;
			fl_s6.nz    <= sd.nz;
			fl_s6.zero  <= sd.zero;
		end
	end

	// CORDIC cells
	vec_t  pv [0:CORDIC_STAGES];
	vec_t  rv [0:CORDIC_STAGES];
	vec_t  yv [0:CORDIC_STAGES];
	flag_t fl_q [0:CORDIC_STAGES-1];

	assign pv[0] = pv_s6;
	assign rv[0] = rv_s6;
	assign yv[0] = yv_s6;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		q2e_cordic_cell #(.IDX(i)) u_pitch (.clk(clk), .en(en), .d(pv[i]), .q(pv[i+1]));
		q2e_cordic_cell #(.IDX(i)) u_roll  (.clk(clk), .en(en), .d(rv[i]), .q(rv[i+1]));
		q2e_cordic_cell #(.IDX(i)) u_yaw   (.clk(clk), .en(en), .d(yv[i]), .q(yv[i+1]));
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					fl_q[i] <= fl_s6;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					fl_q[i] <= fl_q[i-1];
				end
			end
		end
	end

	// degree scaling
	flag_t fl;
	logic [31:0] tp, ty, tr;
	logic [47:0] mp_s7, my_s7, mr_s7;
	logic zero_s7;

	assign fl = fl_q[CORDIC_STAGES-1];

	always_comb begin
		tp = (fl.nz || fl.nil_p) ? '0 : pv[CORDIC_STAGES].ang;
		tr = (fl.nz || fl.nil_r) ? '0 : rv[CORDIC_STAGES].ang;
		if (fl.nz) begin
			ty = '0;
		end else if (fl.sat_p) begin
			ty = TURN_PLUS;
		end else if (fl.sat_n) begin
			ty = TURN_MINUS;
		end else if (fl.nil_y) begin
			ty = '0;
		end else begin
			ty = yv[CORDIC_STAGES].ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mp_s7   <= tp * 16'(DEG_FULL);
			my_s7   <= ty * 16'(DEG_FULL);
			mr_s7   <= tr * 16'(DEG_FULL);
			zero_s7 <= fl.zero;
		end
	end

	function automatic logic [15:0] to_deg(input logic [47:0] m);
		logic [48:0] r;
		logic [16:0] d;
		r = {1'b0, m} + 49'(TURN_HALF);
		d = r[48:32];
		if (d >= 17'(DEG_FULL)) begin
			d = d - 17'(DEG_FULL);
		end
		to_deg = d[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_deg  <= to_deg(mp_s7);
			yaw_deg    <= to_deg(my_s7);
			roll_deg   <= to_deg(mr_s7);
			zero_input <= zero_s7;
		end
	end

endmodule

`default_nettype wire
